// File: sv/assert_macros.svh
// Assertion macros shared by the bracket checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/ccb_pkg.sv
// Types, constants and helpers for the C bracket balance checker.
package ccb_pkg;

    localparam int STACK_DEPTH_DEF = 1024;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR = 8'h2A;

    localparam logic [1:0] ERR_OVERFLOW = 2'd0;
    localparam logic [1:0] ERR_EXTRA = 2'd1;
    localparam logic [1:0] ERR_MISMATCH = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    localparam logic [1:0] OPN_PAREN = 2'd0;
    localparam logic [1:0] OPN_BRACK = 2'd1;
    localparam logic [1:0] OPN_BRACE = 2'd2;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_input;
    } char_beat_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic [7:0] offending_char;
        logic [7:0] open_char;
    } err_beat_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [1:0] code;
    } stack_op_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] top;
    } stack_stat_t;

    function automatic logic [7:0] opener_char(input logic [1:0] code);
        logic [7:0] ch;
        unique case (code)
            OPN_PAREN: ch = CH_LPAREN;
            OPN_BRACK: ch = CH_LBRACK;
            OPN_BRACE: ch = CH_LBRACE;
            default:   ch = 8'd0;
        endcase
        return ch;
    endfunction

    // Bracket kind of an opener or a closer.
    function automatic logic [1:0] bracket_code(input logic [7:0] c);
        logic [1:0] code;
        priority if (c == CH_LPAREN || c == CH_RPAREN)
            code = OPN_PAREN;
        else if (c == CH_LBRACK || c == CH_RBRACK)
            code = OPN_BRACK;
        else
            code = OPN_BRACE;
        return code;
    endfunction

endpackage

// File: sv/ccb_stack.sv
// Opener stack: top in a register, lower entries in a memory with registered read.
`include "assert_macros.svh"

module ccb_stack #(
    parameter int STACK_DEPTH = ccb_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccb_pkg::stack_op_t   op,
    output ccb_pkg::stack_stat_t stat
);
    import ccb_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL_LVL = DW'(STACK_DEPTH);

    logic [1:0]    mem [STACK_DEPTH];

    logic [DW-1:0] depth_reg, depth_next;
    logic [1:0]    top_reg, top_next;
    logic [1:0]    rd_q_reg;
    logic          byp_reg, byp_next;
    logic [1:0]    byp_val_reg;
    logic [1:0]    below;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_lvl;
    logic [DW-1:0] wr_lvl;

    assign below = byp_reg ? byp_val_reg : rd_q_reg;
    assign wr_lvl = depth_reg - DW'(1);
    assign wr_addr = wr_lvl[AW-1:0];
    assign rd_lvl = depth_next - DW'(2);
    assign rd_addr = rd_lvl[AW-1:0];

    assign stat.empty = (depth_reg == '0);
    assign stat.full = (depth_reg == FULL_LVL);
    assign stat.top = top_reg;

    always_comb
    begin
        depth_next = depth_reg;
        top_next = top_reg;
        wr_en = 1'b0;
        byp_next = 1'b0;
        priority if (op.clear)
        begin
            depth_next = '0;
        end
        else if (op.push)
        begin
            depth_next = depth_reg + DW'(1);
            top_next = op.code;
            wr_en = (depth_reg != '0);
            byp_next = 1'b1;
        end
        else if (op.pop)
        begin
            depth_next = depth_reg - DW'(1);
            top_next = below;
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        byp_val_reg <= top_reg;
        rd_q_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
    end

    `ASSERT_IMPLIES(a_push_not_full, clk, rst_n, op.push, !stat.full)
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, op.clear, depth_reg == '0)
    `ASSERT_NEXT(a_push_grows, clk, rst_n, op.push && !op.clear, depth_reg == $past(depth_reg) + DW'(1))

endmodule

// File: sv/ccb_lexer.sv
// Lexer modes, comment and escape flags, and error decisions for one byte per cycle while fire is high.
`include "assert_macros.svh"

module ccb_lexer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  ccb_pkg::char_beat_t  beat,
    input  ccb_pkg::stack_stat_t stat,
    output ccb_pkg::stack_op_t   op,
    output logic                 res_valid,
    output ccb_pkg::err_beat_t   res_beat
);
    import ccb_pkg::*;

    typedef enum logic [2:0] {
        MODE_CODE,
        MODE_CHAR,
        MODE_STRING,
        MODE_LINE,
        MODE_BLOCK,
        MODE_SKIP
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       slash_reg, slash_next;
    logic       star_reg, star_next;
    stack_op_t  op_int;
    logic       err;
    err_beat_t  err_beat;
    logic [7:0] c;
    logic       do_code;
    logic [7:0] quote;

    assign c = beat.byte_req;
    assign quote = (mode_reg == MODE_CHAR) ? CH_SQUOTE : CH_DQUOTE;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next = esc_reg;
        slash_next = slash_reg;
        star_next = star_reg;
        op_int = '0;
        op_int.code = bracket_code(c);
        err = 1'b0;
        err_beat = '0;
        do_code = 1'b0;

        if (beat.end_of_input)
        begin
            if (!stat.empty)
            begin
                err = 1'b1;
                err_beat.error_code = ERR_UNCLOSED;
                err_beat.offending_char = opener_char(stat.top);
                err_beat.open_char = opener_char(stat.top);
            end
            op_int.clear = 1'b1;
            mode_next = MODE_CODE;
            esc_next = 1'b0;
            slash_next = 1'b0;
            star_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_CODE:
                begin
                    do_code = 1'b1;
                    if (slash_reg)
                    begin
                        slash_next = 1'b0;
                        if (c == CH_SLASH)
                        begin
                            mode_next = MODE_LINE;
                            do_code = 1'b0;
                        end
                        else if (c == CH_STAR)
                        begin
                            mode_next = MODE_BLOCK;
                            star_next = 1'b0;
                            do_code = 1'b0;
                        end
                    end
                end
                MODE_CHAR, MODE_STRING:
                begin
                    if (c == CH_BSLASH)
                        esc_next = !esc_reg;
                    else if (c == quote && !esc_reg)
                        mode_next = MODE_CODE;
                    else
                        esc_next = 1'b0;
                end
                MODE_LINE, MODE_SKIP:
                begin
                    if (c == CH_NEWLINE)
                        mode_next = MODE_CODE;
                end
                MODE_BLOCK:
                begin
                    if (star_reg && c == CH_SLASH)
                    begin
                        star_next = 1'b0;
                        mode_next = MODE_CODE;
                    end
                    else
                        star_next = (c == CH_STAR);
                end
                default:
                    mode_next = MODE_CODE;
            endcase

            if (do_code)
            begin
                unique case (c)
                    CH_SQUOTE:
                    begin
                        mode_next = MODE_CHAR;
                        esc_next = 1'b0;
                    end
                    CH_DQUOTE:
                    begin
                        mode_next = MODE_STRING;
                        esc_next = 1'b0;
                    end
                    CH_SLASH:
                        slash_next = 1'b1;
                    CH_LPAREN, CH_LBRACK, CH_LBRACE:
                    begin
                        if (stat.full)
                        begin
                            err = 1'b1;
                            err_beat.error_code = ERR_OVERFLOW;
                            err_beat.offending_char = c;
                        end
                        else
                            op_int.push = 1'b1;
                    end
                    CH_RPAREN, CH_RBRACK, CH_RBRACE:
                    begin
                        if (stat.empty)
                        begin
                            err = 1'b1;
                            err_beat.error_code = ERR_EXTRA;
                            err_beat.offending_char = c;
                        end
                        else if (stat.top != bracket_code(c))
                        begin
                            err = 1'b1;
                            err_beat.error_code = ERR_MISMATCH;
                            err_beat.offending_char = c;
                            err_beat.open_char = opener_char(stat.top);
                        end
                        else
                            op_int.pop = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (err)
            begin
                op_int.push = 1'b0;
                op_int.pop = 1'b0;
                op_int.clear = 1'b1;
                esc_next = 1'b0;
                slash_next = 1'b0;
                star_next = 1'b0;
                mode_next = MODE_SKIP;
            end
        end
    end

    always_comb
    begin
        op = op_int;
        op.push = op_int.push && fire;
        op.pop = op_int.pop && fire;
        op.clear = op_int.clear && fire;
    end

    assign res_valid = err && fire;
    assign res_beat = err_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CODE;
            esc_reg <= 1'b0;
            slash_reg <= 1'b0;
            star_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            esc_reg <= esc_next;
            slash_reg <= slash_next;
            star_reg <= star_next;
        end
    end

    `ASSERT_IMPLIES(a_err_clears, clk, rst_n, res_valid, op.clear && !op.push && !op.pop)
    `ASSERT_NEXT(a_err_skips, clk, rst_n, res_valid && !beat.end_of_input, mode_reg == MODE_SKIP)
    `ASSERT_NEXT(a_eoi_resets, clk, rst_n, fire && beat.end_of_input, mode_reg == MODE_CODE && !slash_reg && !star_reg && !esc_reg)

endmodule

// File: sv/c_bracket_balance_checker.sv
// Top level of the C bracket balance checker: input register, lexer, stack, result register.
//
//   Channel   Dir   Handshake                 Beat
//   char      in    char_valid / char_ready   char_beat (byte_req, end_of_input)
//   err       out   err_valid / err_ready     err_beat (error_code, offending_char, open_char)
//
// One byte per cycle sustained while the result register is free or err_ready is high; a beat
// is held in the input register until it fires, and its result is then registered in the result register.
// Lexer update and one stack push or pop happen in the same cycle; the top opener sits in a
// register and the memory (one write, one registered read per cycle) holds the entries below it.
// Reset clears modes, flags and the depth count; stack memory needs no clearing pass.
// A result waiting in the result register with err_ready low halts processing; an empty input
// register still takes one more beat.
`include "assert_macros.svh"

module c_bracket_balance_checker #(
    parameter int STACK_DEPTH = ccb_pkg::STACK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  ccb_pkg::char_beat_t char_beat,
    output logic                err_valid,
    input  logic                err_ready,
    output ccb_pkg::err_beat_t  err_beat
);
    import ccb_pkg::*;

    logic        in_valid_reg;
    char_beat_t  in_beat_reg;
    logic        err_valid_reg;
    err_beat_t   err_beat_reg;
    logic        fire;
    stack_op_t   op;
    stack_stat_t stat;
    logic        res_valid;
    err_beat_t   res_beat;

    assign fire = in_valid_reg && (!err_valid_reg || err_ready);
    assign char_ready = !in_valid_reg || fire;
    assign err_valid = err_valid_reg;
    assign err_beat = err_beat_reg;

    ccb_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (in_beat_reg),
        .stat      (stat),
        .op        (op),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

    ccb_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .stat  (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            err_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_ready)
                in_valid_reg <= char_valid;
            if (!err_valid_reg || err_ready)
                err_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            in_beat_reg <= char_beat;
        if (res_valid)
            err_beat_reg <= res_beat;
    end

    `ASSERT_IMPLIES(a_fire_has_item, clk, rst_n, fire, in_valid_reg)
    `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst_n, err_valid_reg && !err_ready, !res_valid)
    `ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid, err_valid_reg)

endmodule
